FILE: rtl/core/first_fit_block_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_defines
// assertion macros shared by the allocator checks
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FFBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator check failed");

// consequent must hold in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

FILE: rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// types and constants of the first fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int REQ_W   = 13;  // request_size
    localparam int FADDR_W = 12;  // free_address
    localparam int PADDR_W = 12;  // payload_address
    // rounded request: request plus at most ALIGN_BYTES - 1 alignment bytes
    localparam int RND_W   = 14;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic FIT_FIRST = 1'b0;
    localparam logic FIT_BEST  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE
    } eng_state_t;

    typedef struct packed {
        logic             done;
        logic [RND_W-1:0] size;
    } align_res_t;

    typedef struct packed {
        logic [PADDR_W-1:0] addr;
        logic               status;
        logic               reused;
    } result_t;

endpackage

FILE: rtl/core/ffba_align_unit.sv
// ----------------------------------------------------------------------------
// ffba_align_unit
// rounds a request up to the alignment by a reciprocal multiply
// ----------------------------------------------------------------------------
module ffba_align_unit #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ffba_pkg::REQ_W-1:0] req,
    output ffba_pkg::align_res_t       res
);

    localparam int RND_W  = ffba_pkg::RND_W;
    // n times the rounding error of the reciprocal stays below 2**SHIFT
    localparam int SHIFT  = 20;
    localparam int RCP_W  = SHIFT + 1;
    localparam int PROD_W = RND_W + RCP_W;
    localparam int AL_W   = $clog2(ALIGN_BYTES) + 1;
    localparam int SCL_W  = RND_W + AL_W;
    localparam logic [RCP_W-1:0] RECIP_C =
        RCP_W'((2 ** SHIFT + ALIGN_BYTES - 1) / ALIGN_BYTES);
    localparam logic [RND_W-1:0] BIAS_C  = RND_W'(ALIGN_BYTES - 1);

    logic              busy_reg;
    logic [RND_W-1:0]  n_reg;
    logic [RND_W-1:0]  q_reg;
    logic [RND_W-1:0]  n_next;
    logic [PROD_W-1:0] prod;
    logic [SCL_W-1:0]  scaled;

    assign n_next = RND_W'(req) + BIAS_C;
    // quotient of n by the alignment
    assign prod   = PROD_W'(n_reg) * PROD_W'(RECIP_C);
    assign scaled = SCL_W'(q_reg) * SCL_W'(ALIGN_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= n_next;
        end
        q_reg <= prod[SHIFT +: RND_W];
    end

    assign res.done = !busy_reg;
    assign res.size = scaled[RND_W-1:0];

endmodule

FILE: rtl/core/ffba_heap_engine.sv
// ----------------------------------------------------------------------------
// ffba_heap_engine
// header memory, block walk and the allocate / free decision
// ----------------------------------------------------------------------------
module ffba_heap_engine #(
    parameter int HEAP_BYTES   = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         in_op,
    input  logic [ffba_pkg::REQ_W-1:0]   in_req,
    input  logic [ffba_pkg::FADDR_W-1:0] in_faddr,
    input  logic                         policy,
    input  ffba_pkg::align_res_t         align_i,
    input  logic                         out_free,
    output logic                         idle,
    output logic                         res_valid,
    output ffba_pkg::result_t            res
);

    localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
    localparam int SIZE_W = $clog2(HEAP_BYTES);
    localparam int ENT_W  = SIZE_W + 1;
    localparam int SLOTS  = HEAP_BYTES / 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CMP_W  = ((OFF_W > ffba_pkg::RND_W) ? OFF_W : ffba_pkg::RND_W) + 1;
    localparam logic [CMP_W-1:0] HDR_C  = CMP_W'(HEADER_BYTES);
    localparam logic [CMP_W-1:0] HEAP_C = CMP_W'(HEAP_BYTES);

    ffba_pkg::eng_state_t state_reg, state_next;

    logic                         op_reg;
    logic [ffba_pkg::REQ_W-1:0]   req_reg;
    logic [ffba_pkg::FADDR_W-1:0] faddr_reg;
    logic                         best_reg;
    logic [OFF_W-1:0]             p_reg;
    logic [OFF_W-1:0]             heap_top_reg;
    logic                         have_reg;
    logic [OFF_W-1:0]             found_reg;
    logic [SIZE_W-1:0]            fsize_reg;
    logic [SIZE_W-1:0]            slack_reg;

    logic [ENT_W-1:0] mem [SLOTS];
    logic [ENT_W-1:0] rdata_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;

    logic              ent_used;
    logic [SIZE_W-1:0] ent_size;
    logic [CMP_W-1:0]  size_ext;
    logic [CMP_W-1:0]  req_ext;
    logic              fits;
    logic [SIZE_W-1:0] slack_cur;
    logic              better;
    logic              hit_free;
    logic              upd;
    logic [CMP_W-1:0]  p_next_w;
    logic              walk_end;
    logic              stop_early;
    logic [CMP_W-1:0]  pay_w;
    logic [CMP_W-1:0]  room_w;
    logic [CMP_W-1:0]  asz_w;
    logic [CMP_W-1:0]  found_pay_w;
    logic              oom;
    logic              finish;
    logic              append_ok;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign ent_used  = rdata_reg[SIZE_W];
    assign ent_size  = rdata_reg[SIZE_W-1:0];
    assign size_ext  = CMP_W'(ent_size);
    assign req_ext   = CMP_W'(req_reg);
    assign fits      = !ent_used && (size_ext >= req_ext);
    // req never exceeds size when the block fits
    assign slack_cur = SIZE_W'(size_ext - req_ext);
    assign better    = fits && (!have_reg || (slack_cur < slack_reg));
    assign hit_free  = ((CMP_W'(p_reg) + HDR_C) == CMP_W'(faddr_reg));
    assign upd       = (op_reg == ffba_pkg::OP_FREE) ? hit_free :
                       ((best_reg == ffba_pkg::FIT_BEST) ? better : fits);
    assign p_next_w  = CMP_W'(p_reg) + HDR_C + size_ext;
    assign walk_end  = (p_next_w >= CMP_W'(heap_top_reg));
    assign stop_early = upd && !((op_reg == ffba_pkg::OP_ALLOC) &&
                                 (best_reg == ffba_pkg::FIT_BEST));

    assign pay_w       = CMP_W'(heap_top_reg) + HDR_C;
    assign room_w      = HEAP_C - pay_w;
    assign asz_w       = CMP_W'(align_i.size);
    assign oom         = (pay_w >= HEAP_C) || (asz_w > room_w);
    assign found_pay_w = CMP_W'(found_reg) + HDR_C;
    assign finish      = (state_reg == ffba_pkg::ST_DECIDE) && align_i.done && out_free;
    assign append_ok   = finish && (op_reg == ffba_pkg::OP_ALLOC) && !have_reg && !oom;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = (heap_top_reg == '0) ? ffba_pkg::ST_DECIDE
                                                      : ffba_pkg::ST_WALK;
                end
            end
            ffba_pkg::ST_WALK: begin
                if (stop_early || walk_end) begin
                    state_next = ffba_pkg::ST_DECIDE;
                end
            end
            ffba_pkg::ST_DECIDE: begin
                if (finish) begin
                    state_next = ffba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        idle       = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = found_reg[3 +: SLOT_W];
        wr_data    = {1'b1, fsize_reg};
        res_valid  = 1'b0;
        res.addr   = '0;
        res.status = ffba_pkg::STATUS_OK;
        res.reused = 1'b0;
        case (state_reg)
            ffba_pkg::ST_IDLE: begin
                idle = 1'b1;
            end
            ffba_pkg::ST_WALK: begin
                rd_addr = p_next_w[3 +: SLOT_W];
            end
            ffba_pkg::ST_DECIDE: begin
                res_valid = finish;
                if (op_reg == ffba_pkg::OP_FREE) begin
                    wr_en   = finish && have_reg;
                    wr_data = {1'b0, fsize_reg};
                end else if (have_reg) begin
                    wr_en      = finish;
                    res.addr   = found_pay_w[ffba_pkg::PADDR_W-1:0];
                    res.reused = 1'b1;
                end else if (oom) begin
                    res.status = ffba_pkg::STATUS_OOM;
                end else begin
                    wr_en    = finish;
                    wr_addr  = heap_top_reg[3 +: SLOT_W];
                    wr_data  = {1'b1, asz_w[SIZE_W-1:0]};
                    res.addr = pay_w[ffba_pkg::PADDR_W-1:0];
                end
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ffba_pkg::ST_IDLE;
            heap_top_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (append_ok) begin
                heap_top_reg <= OFF_W'(pay_w + asz_w);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ffba_pkg::ST_IDLE && start) begin
            op_reg    <= in_op;
            req_reg   <= in_req;
            faddr_reg <= in_faddr;
            best_reg  <= policy;
            p_reg     <= '0;
            have_reg  <= 1'b0;
        end else if (state_reg == ffba_pkg::ST_WALK) begin
            if (upd) begin
                have_reg  <= 1'b1;
                found_reg <= p_reg;
                fsize_reg <= ent_size;
                slack_reg <= slack_cur;
            end
            p_reg <= OFF_W'(p_next_w);
        end
    end

endmodule

FILE: rtl/core/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// implicit-list heap allocator with first fit or best fit reuse
// ----------------------------------------------------------------------------
// One item at a time: an allocate or free walks the block headers below the
// heap top and decides before the next item is accepted. The walk reads one
// header per cycle from the single read port of the header memory, and the
// rounding of the request size runs beside it as a reciprocal multiply. A
// finished result waits in the output register while the next item is taken;
// while a result still waits there, the engine holds the next one in its
// decide state. The header memory needs no clearing pass: only headers below
// the heap top are ever used.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top #(
    parameter int HEAP_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [ffba_pkg::REQ_W-1:0]   s_request_size,
    input  logic [ffba_pkg::FADDR_W-1:0] s_free_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ffba_pkg::PADDR_W-1:0] m_payload_address,
    output logic                         m_status,
    output logic                         m_reused,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_fit_policy
);

    logic                 fit_policy_reg;
    logic                 m_valid_reg;
    ffba_pkg::result_t    res_reg;
    ffba_pkg::result_t    eng_res;
    ffba_pkg::align_res_t align_res;
    logic                 eng_idle;
    logic                 eng_res_valid;
    logic                 s_accept;
    logic                 out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = eng_idle;
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= ffba_pkg::FIT_FIRST;
        end else if (cfg_valid && cfg_ready) begin
            fit_policy_reg <= cfg_fit_policy;
        end
    end

    ffba_align_unit #(
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_align (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .req     (s_request_size),
        .res     (align_res)
    );

    ffba_heap_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept),
        .in_op     (s_op),
        .in_req    (s_request_size),
        .in_faddr  (s_free_address),
        .policy    (fit_policy_reg),
        .align_i   (align_res),
        .out_free  (out_free),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    // output register parts the engine from the result channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_valid) begin
            res_reg <= eng_res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_address = res_reg.addr;
    assign m_status          = res_reg.status;
    assign m_reused          = res_reg.reused;

    // an accepted item keeps the engine busy in the cycle after it
    `FFBA_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_ready)
    // the engine never overwrites a result that is still waiting
    `FFBA_ASSERT_SAME(a_no_result_overrun, eng_res_valid, !m_valid_reg || m_ready)
    // out of memory grants nothing
    `FFBA_ASSERT_SAME(a_oom_clean, m_valid && m_status,
                      m_payload_address == '0 && !m_reused)

endmodule
